@@ rtl/core/mbp_pkg.sv @@
// shared types, constants and helper functions for the msb-first bit packer
// no dependencies; imported by every module of the block

package mbp_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 6;
    localparam int BYTE_W         = 8;
    localparam int PEND_W         = BYTE_W - 1;
    localparam int PCNT_W         = 3;
    localparam int ACC_W          = PEND_W + VALUE_W;
    localparam int TOTAL_W        = 6;
    localparam int SAT_BITS       = (MAX_FIELD_BITS < VALUE_W) ? MAX_FIELD_BITS : VALUE_W;
    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_W     = 1;
    localparam int FIFO_CNT_W     = 2;
    localparam int S_TDATA_W      = ((COUNT_W + VALUE_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_APPEND,
        CMD_FLUSH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } back_state_t;

    // low n bits set, (1 << n) - 1
    function automatic logic [VALUE_W-1:0] value_mask(input logic [COUNT_W-1:0] n);
        value_mask = ~({VALUE_W{1'b1}} << n);
    endfunction

    function automatic logic [ACC_W-1:0] acc_mask(input logic [TOTAL_W-1:0] n);
        acc_mask = ~({ACC_W{1'b1}} << n);
    endfunction

endpackage

@@ rtl/core/mbp_front.sv @@
// front end: takes input transactions, saturates the count, masks the value
// and turns each one into an append or flush command; uses mbp_pkg

module mbp_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mbp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           fifo_full,
    output logic                           cmd_push,
    output mbp_pkg::cmd_t                  cmd
);
    import mbp_pkg::*;

    logic [COUNT_W-1:0] raw_count;
    logic [COUNT_W-1:0] sat_count;
    logic [VALUE_W-1:0] raw_value;
    logic               is_flush;

    assign raw_count = s_tdata[COUNT_W-1:0];
    assign raw_value = s_tdata[COUNT_W +: VALUE_W];
    assign is_flush  = s_tuser;

    assign sat_count = (raw_count > COUNT_W'(SAT_BITS)) ? COUNT_W'(SAT_BITS) : raw_count;

    assign s_tready = !fifo_full;

    always_comb begin
        cmd.kind  = is_flush ? CMD_FLUSH : CMD_APPEND;
        cmd.count = sat_count;
        cmd.value = raw_value & value_mask(sat_count);
    end

    // zero-width appends change nothing, so they are dropped here
    assign cmd_push = s_tvalid && s_tready && (is_flush || (sat_count != '0));

endmodule

@@ rtl/core/mbp_cmd_fifo.sv @@
// short command queue between the front and back ends
// uses mbp_pkg for the command type and depth

module mbp_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mbp_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output mbp_pkg::cmd_t pop_data
);
    import mbp_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/mbp_back.sv @@
// back end: holds the partial-byte accumulator and emits one byte per cycle
// into the output register whenever it is free; uses mbp_pkg

module mbp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    input  mbp_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mbp_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import mbp_pkg::*;

    back_state_t          state_reg, state_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [PEND_W-1:0]    pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0]    pend_cnt_reg, pend_cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic                 out_free;
    logic [ACC_W-1:0]     sum_acc;
    logic [TOTAL_W-1:0]   sum_total;
    logic [TOTAL_W-1:0]   rem;
    logic [PCNT_W:0]      pad_shift;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign sum_acc   = (ACC_W'(pend_bits_reg) << cmd.count) | ACC_W'(cmd.value);
    assign sum_total = TOTAL_W'(pend_cnt_reg) + TOTAL_W'(cmd.count);
    assign rem       = total_reg - TOTAL_W'(BYTE_W);
    assign pad_shift = (PCNT_W + 1)'(BYTE_W) - {1'b0, pend_cnt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        total_reg   <= total_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        cmd_pop        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_FLUSH) begin
                        // partial byte goes out top-aligned, zero below
                        if (pend_cnt_reg != '0) begin
                            acc_next   = ACC_W'(pend_bits_reg) << pad_shift;
                            total_next = TOTAL_W'(BYTE_W);
                            state_next = ST_EMIT;
                        end
                    end else if (sum_total >= TOTAL_W'(BYTE_W)) begin
                        acc_next   = sum_acc;
                        total_next = sum_total;
                        state_next = ST_EMIT;
                    end else begin
                        pend_bits_next = sum_acc[PEND_W-1:0];
                        pend_cnt_next  = sum_total[PCNT_W-1:0];
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = BYTE_W'(acc_reg >> rem);
                    m_tlast_next  = (rem < TOTAL_W'(BYTE_W));
                    total_next    = rem;
                    if (rem < TOTAL_W'(BYTE_W)) begin
                        pend_bits_next = PEND_W'(acc_reg & acc_mask(rem));
                        pend_cnt_next  = rem[PCNT_W-1:0];
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // emitting always has at least one whole byte left in the accumulator
    a_emit_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (total_reg >= TOTAL_W'(BYTE_W)))
        else $error("emit state without a whole byte");

    // buffered bits above the fill count stay clear
    a_pend_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        ((ACC_W'(pend_bits_reg) & ~acc_mask(TOTAL_W'(pend_cnt_reg))) == '0))
        else $error("stale bits above pending count");

    // commands are taken only while no byte sequence is in progress
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == ST_IDLE && cmd_valid))
        else $error("command popped while emitting");

    // a flush with buffered bits ends aligned after its single byte
    a_flush_aligns: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && cmd.kind == CMD_FLUSH) |=> (pend_cnt_reg == '0 || state_reg == ST_EMIT))
        else $error("flush left the stream unaligned");

endmodule

@@ rtl/core/msb_first_bit_packer.sv @@
// msb-first bit packer: appends 0..32 bit fields to a byte stream
// a byte reaches m_tvalid through the command queue, the accumulator and the output register
// an item giving bytes is loaded into the accumulator, then sends one byte per cycle through
// the output register while that is free; the next item is not taken until its last byte is out
// a two-entry command queue lets the input side keep accepting while bytes drain
// reset: aresetn synchronous active low; clears the queue, pending bits and output valid

module msb_first_bit_packer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mbp_pkg::S_TDATA_W-1:0]  s_tdata,   // bit_count[5:0], field_value[37:6], zero pad
    input  logic                           s_tuser,   // action: 0 append, 1 flush and byte-align
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mbp_pkg::BYTE_W-1:0]     m_tdata,   // out_byte[7:0], first stream bit in bit 7
    output logic                           m_tlast    // last byte caused by one input transaction
);
    import mbp_pkg::*;

    // front to queue
    logic cmd_push;
    cmd_t push_cmd;
    logic fifo_full;

    // queue to back
    logic cmd_valid;
    logic cmd_pop;
    cmd_t head_cmd;

    // classify and normalize each input transaction
    mbp_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd)
    );

    // decouples input acceptance from byte emission
    mbp_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .pop_data  (head_cmd)
    );

    // accumulator and byte emitter with registered output
    mbp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/sv/msb_first_bit_packer_tb.sv @@
// self-checking testbench for msb_first_bit_packer: directed and random append/flush traffic
// with random idling on both sides, checked against a bit-level scoreboard
// depends on mbp_pkg and the msb_first_bit_packer rtl

class packer_scoreboard;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    stream_byte_t byte_q[$];
    logic [6:0]   held_bits;
    logic [2:0]   held_count;
    int           errors;
    int           items_seen;
    int           flushes_seen;
    int           saturated_seen;
    int           bytes_checked;

    function new();
        held_bits      = '0;
        held_count     = '0;
        errors         = 0;
        items_seen     = 0;
        flushes_seen   = 0;
        saturated_seen = 0;
        bytes_checked  = 0;
    endfunction

    function int outstanding();
        return byte_q.size();
    endfunction

    // work out the bytes one accepted transaction must produce and queue them
    function void note_item(mbp_pkg::cmd_kind_t kind, logic [5:0] count, logic [31:0] value);
        stream_byte_t sb_entry;
        logic [14:0]  flush_word;
        logic [63:0]  acc;
        logic [63:0]  keep;
        int unsigned  bits;
        int unsigned  total;
        int           made;
        items_seen++;
        made = 0;
        if (kind == mbp_pkg::CMD_FLUSH) begin
            flushes_seen++;
            if (held_count != 0) begin
                // buffered bits go to the top of the byte, zeros below
                flush_word     = {8'd0, held_bits} << (8 - held_count);
                sb_entry.data  = flush_word[7:0];
                sb_entry.last  = 1'b1;
                byte_q.push_back(sb_entry);
            end
            held_bits  = '0;
            held_count = '0;
            return;
        end
        bits = count;
        if (bits > mbp_pkg::SAT_BITS) begin
            bits = mbp_pkg::SAT_BITS;
            saturated_seen++;
        end
        if (bits == 0)
            return;
        keep  = (64'd1 << bits) - 64'd1;
        acc   = ({57'd0, held_bits} << bits) | ({32'd0, value} & keep);
        total = held_count + bits;
        while (total >= 8) begin
            total         -= 8;
            sb_entry.data  = 8'(acc >> total);
            sb_entry.last  = 1'b0;
            byte_q.push_back(sb_entry);
            made++;
        end
        if (made > 0)
            byte_q[byte_q.size() - 1].last = 1'b1;
        held_count = 3'(total);
        held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
    endfunction

    function void check_byte(logic [7:0] data, logic last);
        stream_byte_t want;
        if (byte_q.size() == 0) begin
            $error("out_byte: expected none, got %h (tlast %b)", data, last);
            errors++;
            return;
        end
        want = byte_q.pop_front();
        bytes_checked++;
        if (data !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, data);
            errors++;
        end
        if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
        end
    endfunction

endclass

module msb_first_bit_packer_tb;

    import mbp_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no transaction before giving up
    localparam int LONG_HOLD   = 80;     // receiver hold-off used to back up the block
    localparam int TAIL_CYCLES = 8;      // settle time after the last expected byte
    localparam int RANDOM_ITEMS = 88;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // bit_count[5:0], field_value[37:6], zero pad
    logic                 s_tuser  = 1'b0; // action: 0 append, 1 flush and byte-align
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;         // out_byte[7:0], first stream bit in bit 7
    logic                 m_tlast;         // last byte caused by one input transaction

    packer_scoreboard sb;

    // no_idle turns both sides into back-to-back traffic for a stretch
    bit no_idle   = 1'b0;
    int hold_req  = 0;
    int quiet_cnt = 0;

    msb_first_bit_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // sampled at the edge: both channels see pre-edge values, so no ordering race
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(cmd_kind_t'(s_tuser), s_tdata[COUNT_W-1:0],
                             s_tdata[COUNT_W +: VALUE_W]);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tlast);
        end
    end

    // watchdog: any stretch with no transaction on either side counts toward the limit
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt == STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("msb_first_bit_packer_tb: errors");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // receiver: random stall before each byte, or one long hold-off when asked
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // offer one item after a random gap and hold it until the block takes it
    task automatic send_item(cmd_kind_t kind, logic [5:0] count, logic [31:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - COUNT_W){1'b0}}, value, count};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic append_bits(logic [5:0] count, logic [31:0] value);
        send_item(CMD_APPEND, count, value);
    endtask

    task automatic flush_stream();
        send_item(CMD_FLUSH, 6'($urandom_range(0, 63)), $urandom);
    endtask

    // sender pause: let every expected byte drain, then give the back end time to settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        // let the last accepted transaction reach the scoreboard first
        @(posedge aclk);
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // one random item, weighted toward appends of useful widths
    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            flush_stream();
        else if (pick < 15)
            append_bits(6'd0, $urandom);
        else if (pick < 55)
            append_bits(6'($urandom_range(1, 8)), $urandom);
        else if (pick < 80)
            append_bits(6'($urandom_range(9, 31)), $urandom);
        else if (pick < 95)
            append_bits(6'd32, $urandom);
        else
            append_bits(6'($urandom_range(33, 63)), $urandom);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: alignment corners, zero count, saturation, full-width fields
        flush_stream();                          // flush with nothing buffered
        append_bits(6'd0, 32'hFFFF_FFFF);        // zero count does nothing
        append_bits(6'd1, 32'hFFFF_FFFF);        // one bit, no byte yet
        flush_stream();                          // single buffered bit padded with zeros
        append_bits(6'd7, 32'h0000_007F);
        append_bits(6'd1, 32'h0000_0000);        // completes a byte exactly
        append_bits(6'd8, 32'hA5A5_A5A5);        // aligned whole byte
        append_bits(6'd32, 32'hFFFF_FFFF);
        append_bits(6'd32, 32'h0000_0000);
        append_bits(6'd3, 32'h0000_0005);
        append_bits(6'd63, 32'h1234_5678);       // count saturates at the field width
        append_bits(6'd33, 32'hFFFF_FFFF);
        append_bits(6'd4, 32'h0000_0009);
        append_bits(6'd0, 32'h8000_0001);        // zero count with bits buffered
        flush_stream();
        flush_stream();                          // second flush is already aligned
        append_bits(6'd7, 32'h0000_0055);
        append_bits(6'd32, 32'hDEAD_BEEF);       // seven buffered plus 32 gives four bytes
        flush_stream();
        append_bits(6'd5, 32'h0000_001F);
        flush_stream();
        wait_drained();

        // random traffic in segments; one segment runs with no idling at all
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 40 && i < 60);
            // back the block up: long receiver hold while wide appends keep coming
            if (i == 70)
                hold_req = LONG_HOLD;
            if (i >= 70 && i < 80)
                append_bits(6'd32, $urandom);
            else
                random_item();
            if (i == 85)
                wait_drained();
        end
        no_idle = 1'b0;
        flush_stream();
        wait_drained();

        $display("covered %0d items (%0d flushes, %0d saturated counts), %0d bytes checked",
                 sb.items_seen, sb.flushes_seen, sb.saturated_seen, sb.bytes_checked);
        if (sb.errors == 0) begin
            $display("msb_first_bit_packer_tb: clean");
        end else begin
            $display("msb_first_bit_packer_tb: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/mbp_pkg.sv
rtl/core/mbp_front.sv
rtl/core/mbp_cmd_fifo.sv
rtl/core/mbp_back.sv
rtl/core/msb_first_bit_packer.sv
tb/sv/msb_first_bit_packer_tb.sv
